// ===== src/utp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_pkg - shared types and constants of the USB endpoint tx packetizer
// Word layouts, endpoint state record, op and status codes, FSM states.
// ----------------------------------------------------------------------------
package utp_pkg;

    localparam int ENDPOINTS   = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam int EP_W   = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int QA_W   = EP_W + SLOT_W;
    localparam int TOT_W  = $clog2(ENDPOINTS * QUEUE_DEPTH + 1);

    localparam logic [9:0] LEN_CAP   = 10'h3FF;
    localparam int         FLUSH_SAT = 127;

    // op codes
    localparam logic [1:0] OP_QUEUE = 2'd0;
    localparam logic [1:0] OP_CONT  = 2'd1;
    localparam logic [1:0] OP_SET   = 2'd2;
    localparam logic [1:0] OP_RESET = 2'd3;

    // status codes
    localparam logic [2:0] STAT_IDLE      = 3'd0;
    localparam logic [2:0] STAT_BOTH_BUSY = 3'd1;
    localparam logic [2:0] STAT_ISSUED    = 3'd2;
    localparam logic [2:0] STAT_RETIRED   = 3'd3;
    localparam logic [2:0] STAT_QUEUED    = 3'd4;
    localparam logic [2:0] STAT_FULL      = 3'd5;
    localparam logic [2:0] STAT_SIZE_SET  = 3'd6;
    localparam logic [2:0] STAT_RST_DONE  = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  endpoint;
        logic [31:0] buf_addr;
        logic [15:0] length;
        logic [9:0]  max_packet;
        logic        own_even;
        logic        own_odd;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic        bank_odd;
        logic        data_toggle;
        logic [31:0] pkt_addr;
        logic [9:0]  pkt_len;
        logic        completed;
        logic [6:0]  flushed_count;
    } t_out_word;

    // per-endpoint state record
    typedef struct packed {
        logic              odd;
        logic              toggle;
        logic [9:0]        mp;
        logic [SLOT_W-1:0] head;
        logic [CNT_W-1:0]  count;
        logic [15:0]       pos;
    } t_ep_state;

    // queued transfer
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] len;
    } t_qent;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SEGMENT,
        S_FLUSH,
        S_DELIVER
    } t_fsm_state;

endpackage

// ===== src/usb_endpoint_tx_packetizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_endpoint_tx_packetizer - per-endpoint USB tx segmentation engine
// Queue, max-packet-size, continue and flush words on a valid/stall channel;
// one result word per input word through an output register.
// A queue, set or continue word passes through lookup (registered state-memory
// read), a continue on a non-empty queue then through segment (queue-memory read),
// and then deliver; a flush word instead goes to the flush sweep, which touches
// one endpoint entry per cycle, and then to deliver. The input stalls until the
// result is loaded, so no new word is taken while one is still in flight.
// Reset: synchronous; all queues empty, all endpoint state reads as zero.
// ----------------------------------------------------------------------------
module usb_endpoint_tx_packetizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  utp_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output utp_pkg::t_out_word o_out
);
    import utp_pkg::*;

    t_fsm_state r_state, n_state;
    t_in_word   r_item, n_item;
    t_out_word  r_res, n_res;
    t_out_word  r_out;
    logic       r_out_valid;
    logic [EP_W-1:0]  r_fidx, n_fidx;
    logic [TOT_W-1:0] r_ftotal, n_ftotal;

    // memory ports
    logic [EP_W-1:0] st_rd_addr, st_wr_addr;
    t_ep_state       st_rd, st_wr_data;
    logic            st_wr_en;
    logic [QA_W-1:0] q_rd_addr, q_wr_addr;
    t_qent           q_rd, q_wr_data;
    logic            q_wr_en;

    logic            accept, out_free, out_of_range, full, flush_last;
    logic [EP_W-1:0] ep;

    // slot and head arithmetic
    logic [CNT_W:0]    slot_sum, slot_full;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W:0]   head_sum;
    logic [SLOT_W-1:0] head_nx;

    // segmentation arithmetic
    logic        first_busy, other_busy, bank1;
    logic [16:0] diff;
    logic [15:0] rem, plen_raw;
    logic [9:0]  plen;
    logic [TOT_W-1:0] ftotal_sum;

    utp_state_ram u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data)
    );

    utp_queue_ram u_queue (
        .i_clk     (i_clk),
        .i_rd_addr (q_rd_addr),
        .o_rd_data (q_rd),
        .i_wr_en   (q_wr_en),
        .i_wr_addr (q_wr_addr),
        .i_wr_data (q_wr_data)
    );

    assign accept       = i_in_valid && !o_in_stall;
    assign o_in_stall   = (r_state != S_IDLE);
    assign out_free     = !r_out_valid || !i_out_stall;
    assign ep           = r_item.endpoint[EP_W-1:0];
    assign out_of_range = ({1'b0, r_item.endpoint} >= 5'(ENDPOINTS));
    assign full         = (32'(st_rd.count) >= QUEUE_DEPTH);
    assign flush_last   = (r_fidx == EP_W'(ENDPOINTS - 1));

    // tail slot = (head + count) mod depth
    assign slot_sum  = (CNT_W+1)'(st_rd.head) + (CNT_W+1)'(st_rd.count);
    assign slot_full = (32'(slot_sum) >= QUEUE_DEPTH) ?
                       slot_sum - (CNT_W+1)'(QUEUE_DEPTH) : slot_sum;
    assign slot      = slot_full[SLOT_W-1:0];

    // head advance on pop
    assign head_sum = {1'b0, st_rd.head} + (SLOT_W+1)'(1);
    assign head_nx  = (32'(head_sum) == QUEUE_DEPTH) ? '0 : head_sum[SLOT_W-1:0];

    // bank pick and packet length
    assign first_busy = st_rd.odd ? r_item.own_odd : r_item.own_even;
    assign other_busy = st_rd.odd ? r_item.own_even : r_item.own_odd;
    assign bank1      = st_rd.odd ^ first_busy;
    assign diff       = {1'b0, q_rd.len} - {1'b0, st_rd.pos};
    assign rem        = diff[16] ? 16'd0 : diff[15:0];
    assign plen_raw   = (rem < {6'd0, st_rd.mp}) ? rem : {6'd0, st_rd.mp};
    assign plen       = (plen_raw > {6'd0, LEN_CAP}) ? LEN_CAP : plen_raw[9:0];

    assign ftotal_sum = r_ftotal + TOT_W'(st_rd.count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in.op == OP_RESET) ? S_FLUSH : S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (!out_of_range && r_item.op == OP_CONT && st_rd.count != '0) begin
                    n_state = S_SEGMENT;
                end else begin
                    n_state = S_DELIVER;
                end
            end
            S_SEGMENT: n_state = S_DELIVER;
            S_FLUSH: begin
                if (flush_last) begin
                    n_state = S_DELIVER;
                end
            end
            S_DELIVER: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_item     = r_item;
        n_res      = r_res;
        n_fidx     = r_fidx;
        n_ftotal   = r_ftotal;
        st_rd_addr = ep;
        st_wr_en   = 1'b0;
        st_wr_addr = ep;
        st_wr_data = st_rd;
        q_rd_addr  = {ep, st_rd.head};
        q_wr_en    = 1'b0;
        q_wr_addr  = {ep, slot};
        q_wr_data  = '{addr: r_item.buf_addr, len: r_item.length};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item     = i_in;
                    n_fidx     = '0;
                    n_ftotal   = '0;
                    st_rd_addr = (i_in.op == OP_RESET) ? '0 : i_in.endpoint[EP_W-1:0];
                end
            end
            S_LOOKUP: begin
                n_res = '0;
                if (!out_of_range) begin
                    unique case (r_item.op)
                        OP_QUEUE: begin
                            if (full) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                q_wr_en          = 1'b1;
                                st_wr_en         = 1'b1;
                                st_wr_data.count = st_rd.count + CNT_W'(1);
                                n_res.status     = STAT_QUEUED;
                            end
                        end
                        OP_SET: begin
                            st_wr_en      = 1'b1;
                            st_wr_data.mp = r_item.max_packet;
                            n_res.status  = STAT_SIZE_SET;
                        end
                        OP_CONT: begin
                            // empty queue leaves status idle
                        end
                        OP_RESET: begin
                            // handled by the flush sweep
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEGMENT: begin
                n_res = '0;
                if (first_busy && other_busy) begin
                    n_res.status = STAT_BOTH_BUSY;
                end else if (rem == 16'd0 && q_rd.len != 16'd0) begin
                    // finished transfer: pop it
                    st_wr_en         = 1'b1;
                    st_wr_data.odd   = bank1;
                    st_wr_data.head  = head_nx;
                    st_wr_data.count = st_rd.count - CNT_W'(1);
                    st_wr_data.pos   = '0;
                    n_res.status     = STAT_RETIRED;
                    n_res.completed  = 1'b1;
                end else begin
                    st_wr_en          = 1'b1;
                    st_wr_data.odd    = ~bank1;
                    st_wr_data.toggle = ~st_rd.toggle;
                    n_res.status      = STAT_ISSUED;
                    n_res.bank_odd    = bank1;
                    n_res.data_toggle = st_rd.toggle;
                    n_res.pkt_addr    = q_rd.addr + {16'd0, st_rd.pos};
                    n_res.pkt_len     = plen;
                    if (q_rd.len == 16'd0) begin
                        // zero-length transfer retires with its empty packet
                        st_wr_data.head  = head_nx;
                        st_wr_data.count = st_rd.count - CNT_W'(1);
                        st_wr_data.pos   = '0;
                        n_res.completed  = 1'b1;
                    end else begin
                        // plen never exceeds what is left, so no overrun
                        st_wr_data.pos = st_rd.pos + {6'd0, plen};
                    end
                end
            end
            S_FLUSH: begin
                st_rd_addr       = r_fidx + EP_W'(1);
                st_wr_en         = 1'b1;
                st_wr_addr       = r_fidx;
                st_wr_data.head  = '0;
                st_wr_data.count = '0;
                st_wr_data.pos   = '0;
                n_fidx           = r_fidx + EP_W'(1);
                n_ftotal         = ftotal_sum;
                n_res               = '0;
                n_res.status        = STAT_RST_DONE;
                n_res.completed     = (ftotal_sum != '0);
                n_res.flushed_count = (32'(ftotal_sum) > FLUSH_SAT) ?
                                      7'(FLUSH_SAT) : 7'(ftotal_sum);
            end
            S_DELIVER: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DELIVER && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_res    <= n_res;
        r_fidx   <= n_fidx;
        r_ftotal <= n_ftotal;
        if (r_state == S_DELIVER && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a new result only comes out of the deliver state
    a_out_from_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DELIVER)
        else $error("result word appeared outside deliver");

    // state memory is never written while waiting for a word
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !st_wr_en && !q_wr_en)
        else $error("memory write while idle");

    // flush sweep ends in deliver after the last endpoint
    a_flush_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && flush_last) |=> (r_state == S_DELIVER))
        else $error("flush sweep did not finish");

    // deliver with a free output register loads it and returns to idle
    a_deliver_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DELIVER && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("result word not loaded");

endmodule

// ===== src/utp_state_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_state_ram - per-endpoint state memory
// One write and one read port, registered read. Per-entry valid bits make
// an entry read as all zero until it is first written after reset.
// ----------------------------------------------------------------------------
module utp_state_ram (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [utp_pkg::EP_W-1:0]  i_rd_addr,
    output utp_pkg::t_ep_state        o_rd_data,
    input  logic                      i_wr_en,
    input  logic [utp_pkg::EP_W-1:0]  i_wr_addr,
    input  utp_pkg::t_ep_state        i_wr_data
);
    import utp_pkg::*;

    t_ep_state            r_mem [ENDPOINTS];
    logic [ENDPOINTS-1:0] r_valid;
    t_ep_state            r_rd_data;
    logic                 r_rd_valid;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== src/utp_queue_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utp_queue_ram - transfer queue memory
// Address and length of each queued transfer, indexed {endpoint, slot}.
// ----------------------------------------------------------------------------
module utp_queue_ram (
    input  logic                      i_clk,
    input  logic [utp_pkg::QA_W-1:0]  i_rd_addr,
    output utp_pkg::t_qent            o_rd_data,
    input  logic                      i_wr_en,
    input  logic [utp_pkg::QA_W-1:0]  i_wr_addr,
    input  utp_pkg::t_qent            i_wr_data
);
    import utp_pkg::*;

    t_qent r_mem [2**QA_W];
    t_qent r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
